// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Implication checked on the following clock edge.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- rtl/core/riec_pkg.sv -----
// Shared types, codes and helpers of the integer execute core.
// No dependencies.
package riec_pkg;
    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;
    localparam logic [1:0] KIND_HALT  = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [2:0] LM_LB  = 3'd0;
    localparam logic [2:0] LM_LBU = 3'd1;
    localparam logic [2:0] LM_LH  = 3'd2;
    localparam logic [2:0] LM_LHU = 3'd3;
    localparam logic [2:0] LM_LW  = 3'd4;

    localparam logic [31:0] HALT_RESET = 32'h0000_2000;
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

    // shared unit operations
    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR, ALU_SLT, ALU_SLTU
    } alu_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mem_address;
        logic [31:0] store_value;
        logic [1:0]  access_size;
        logic [31:0] next_pc;
        logic        invalid_instr;
    } result_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction
endpackage

// ----- rtl/core/riec_alu.sv -----
// Shared arithmetic and compare unit of the integer execute core.
// Depends on riec_pkg.
module riec_alu
    import riec_pkg::*;
(
    input  alu_op_t     op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    always_comb
    begin
        unique case (op)
            ALU_ADD:  y = a + b;
            ALU_SUB:  y = a - b;
            ALU_AND:  y = a & b;
            ALU_OR:   y = a | b;
            ALU_XOR:  y = a ^ b;
            ALU_NOR:  y = ~(a | b);
            ALU_SLT:  y = {31'd0, ((a ^ SIGN_BIT) < (b ^ SIGN_BIT))};
            ALU_SLTU: y = {31'd0, (a < b)};
            default:  y = 32'd0;
        endcase
    end
endmodule

// ----- rtl/core/riec_muldiv.sv -----
// Iterative multiply/divide unit: one bit a cycle, 32 steps.
// Depends on riec_pkg.
module riec_muldiv
    import riec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] hi,
    output logic [31:0] lo
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next, spec_reg, spec_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] ma, mb;
    logic [32:0] sum, trial;
    logic [31:0] nq, nr;

    assign ma = a[31] ? (32'd0 - a) : a;
    assign mb = b[31] ? (32'd0 - b) : b;
    assign sum = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, m_reg} : 33'd0);
    assign trial = {acc_reg, q_reg[31]} - {1'b0, m_reg};
    assign nq = qneg_reg ? (32'd0 - q_reg) : q_reg;
    assign nr = rneg_reg ? (32'd0 - acc_reg) : acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        spec_next = spec_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        m_next    = m_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            div_next  = is_div;
            acc_next  = 32'd0;
            spec_next = 1'b0;
            // signed multiply: |a|*|b| then negate 64-bit product
            q_next    = ma;
            m_next    = mb;
            qneg_next = a[31] ^ b[31];
            rneg_next = a[31];
            if (is_div && b == 32'd0)
            begin
                spec_next = 1'b1;
                acc_next  = a;
                q_next    = 32'hFFFF_FFFF;
                qneg_next = 1'b0;
                rneg_next = 1'b0;
            end
            else if (is_div && a == SIGN_BIT && b == 32'hFFFF_FFFF)
            begin
                spec_next = 1'b1;
                acc_next  = 32'd0;
                q_next    = SIGN_BIT;
                qneg_next = 1'b0;
                rneg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (spec_reg || cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
                if (div_reg)
                begin
                    if (!trial[32])
                    begin
                        acc_next = trial[31:0];
                        q_next   = {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {acc_reg[30:0], q_reg[31]};
                        q_next   = {q_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    acc_next = sum[32:1];
                    q_next   = {sum[0], q_reg[31:1]};
                end
            end
        end
    end

    always_comb
    begin
        if (div_reg || spec_reg)
        begin
            hi = nr;
            lo = nq;
        end
        else
        begin
            {hi, lo} = qneg_reg ? (64'd0 - {acc_reg, q_reg}) : {acc_reg, q_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            div_reg  <= 1'b0;
            spec_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
            spec_reg <= spec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        m_reg    <= m_next;
    end
endmodule

// ----- rtl/core/risc_integer_execute_core.sv -----
// Top level of the integer execute core: sequencer, register file, ports.
// Depends on riec_pkg, riec_alu and riec_muldiv.
//
// Executes one request at a time. An instruction is accepted, reads rs, reads rt,
// executes and then passes through an output state, after which the core is
// ready again. MULT and DIV wait in between for the shared one-bit-a-cycle
// multiply/divide unit, which ends early on divide by zero and divide overflow.
// A load reply, an instruction seen while halted and an instruction seen while
// a load is pending skip the register reads and execution and go to the output.
// Results move into a separate output register, so the core only holds in its
// output cycle when a new result is ready and the previous one still waits.
// Register file reads go through one registered memory port, so rs and rt are
// read in turn; registers read as zero until first written.
module risc_integer_execute_core
    import riec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_word[31:0], load_value[63:32]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // mem_address[31:0], store_value[63:32], access_size[65:64],
    // next_pc[97:66], invalid_instr[98], zero pad
    output logic [103:0] m_tdata,
    output logic [1:0]  m_tuser,   // result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_EXEC, ST_MULDIV, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] halt_reg, pc_reg, hi_reg, lo_reg;
    logic [31:0] ir_reg, lv_reg, a_reg;
    logic        rtype_reg;
    logic [4:0]  ld_dest_reg;
    logic [2:0]  ld_mode_reg;
    logic        ld_pend_reg;
    result_t     res_reg;
    result_t     out_reg;
    logic        valid_reg;

    logic [31:0] rf [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] rf_rdata;
    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] simm, b_val, pc4, addr, jtgt, btgt;
    alu_op_t     alu_op;
    logic [31:0] alu_a, alu_b, alu_y;
    logic        md_start, md_done;
    logic [31:0] md_hi, md_lo;
    logic [31:0] ldv;

    assign op   = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sh   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign imm  = ir_reg[15:0];
    assign simm = sext16(imm);
    assign b_val = rf_rdata;
    assign pc4  = pc_reg + 32'd4;
    assign addr = a_reg + simm;
    assign jtgt = {pc4[31:28], ir_reg[25:0], 2'b00};
    assign btgt = pc4 + {simm[29:0], 2'b00};

    assign pready = 1'b1;
    assign prdata = halt_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.invalid_instr, out_reg.next_pc, out_reg.access_size,
                       out_reg.store_value, out_reg.mem_address};

    // register file read port: rs in ST_RD_A, rt otherwise
    assign rf_raddr = (state_reg == ST_RD_A) ? rs : rt;

    always_ff @(posedge clk)
    begin
        rf_rdata <= (rf_raddr == 5'd0 || !rf_vld_reg[rf_raddr]) ? 32'd0 : rf[rf_raddr];
        if (rf_we && rf_waddr != 5'd0)
            rf[rf_waddr] <= rf_wdata;
    end

    // mark registers once written; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rf_vld_reg <= 32'd0;
        else if (rf_we && rf_waddr != 5'd0)
            rf_vld_reg[rf_waddr] <= 1'b1;
    end

    // ALU operand selection for the executing instruction
    always_comb
    begin
        alu_a  = a_reg;
        alu_b  = b_val;
        alu_op = ALU_ADD;
        if (op == 6'h00)
        begin
            unique case (fn)
                6'h22:   alu_op = ALU_SUB;
                6'h24:   alu_op = ALU_AND;
                6'h25:   alu_op = ALU_OR;
                6'h26:   alu_op = ALU_XOR;
                6'h27:   alu_op = ALU_NOR;
                6'h2A:   alu_op = ALU_SLT;
                default: alu_op = ALU_ADD;
            endcase
        end
        else
        begin
            alu_b = simm;
            unique case (op)
                6'h0A:   alu_op = ALU_SLT;
                6'h0B:   alu_op = ALU_SLTU;
                6'h0C:
                begin
                    alu_op = ALU_AND;
                    alu_b  = {16'd0, imm};
                end
                6'h0D:
                begin
                    alu_op = ALU_OR;
                    alu_b  = {16'd0, imm};
                end
                6'h0E:
                begin
                    alu_op = ALU_XOR;
                    alu_b  = {16'd0, imm};
                end
                default: alu_op = ALU_ADD;
            endcase
        end
    end

    riec_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

    assign md_start = (state_reg == ST_EXEC) && (op == 6'h00)
                      && (fn == 6'h18 || fn == 6'h1A);

    riec_muldiv u_muldiv (
        .clk(clk), .rst_n(rst_n), .start(md_start), .is_div(fn == 6'h1A),
        .a(a_reg), .b(b_val), .done(md_done), .hi(md_hi), .lo(md_lo)
    );

    always_comb
    begin
        unique case (ld_mode_reg)
            LM_LB:   ldv = {{24{lv_reg[7]}}, lv_reg[7:0]};
            LM_LBU:  ldv = {24'd0, lv_reg[7:0]};
            LM_LH:   ldv = sext16(lv_reg[15:0]);
            LM_LHU:  ldv = {16'd0, lv_reg[15:0]};
            default: ldv = lv_reg;
        endcase
    end

    // write-back decode in ST_EXEC; load reply in ST_RD_A with rtype set
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = rd;
        rf_wdata = alu_y;
        if (state_reg == ST_RD_A && rtype_reg)
        begin
            rf_we    = ld_pend_reg;
            rf_waddr = ld_dest_reg;
            rf_wdata = ldv;
        end
        else if (state_reg == ST_EXEC)
        begin
            if (op == 6'h00)
            begin
                rf_waddr = rd;
                unique case (fn)
                    6'h00:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = b_val << sh;
                    end
                    6'h02:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = b_val >> sh;
                    end
                    6'h03:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = $signed(b_val) >>> sh;
                    end
                    6'h10:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = hi_reg;
                    end
                    6'h12:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = lo_reg;
                    end
                    6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h27, 6'h2A:
                        rf_we = 1'b1;
                    default: rf_we = 1'b0;
                endcase
            end
            else
            begin
                rf_waddr = rt;
                unique case (op)
                    6'h03:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = 5'd31;
                        rf_wdata = pc4;
                    end
                    6'h08, 6'h09, 6'h0A, 6'h0B, 6'h0C, 6'h0D, 6'h0E: rf_we = 1'b1;
                    6'h0F:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = {imm, 16'd0};
                    end
                    default: rf_we = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            halt_reg    <= HALT_RESET;
            pc_reg      <= 32'd0;
            hi_reg      <= 32'd0;
            lo_reg      <= 32'd0;
            ld_dest_reg <= 5'd0;
            ld_mode_reg <= LM_LB;
            ld_pend_reg <= 1'b0;
            valid_reg   <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'd0)
                halt_reg <= pwdata;
            // load the output register once the previous result has drained
            if (state_reg == ST_OUT && (!valid_reg || m_tready))
            begin
                valid_reg <= 1'b1;
                out_reg   <= res_reg;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        ir_reg    <= s_tdata[31:0];
                        lv_reg    <= s_tdata[63:32];
                        rtype_reg <= s_tuser;
                        state_reg <= ST_RD_A;
                    end
                end
                ST_RD_A:
                begin
                    res_reg <= '{kind: (pc_reg >= halt_reg) ? KIND_HALT : KIND_FETCH,
                                 mem_address: 32'd0, store_value: 32'd0,
                                 access_size: SIZE_BYTE, next_pc: pc_reg,
                                 invalid_instr: 1'b0};
                    if (rtype_reg)
                    begin
                        ld_pend_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                    else if (pc_reg >= halt_reg || ld_pend_reg)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    a_reg     <= rf_rdata;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    logic [31:0] npc;
                    logic        inv;
                    npc = pc4;
                    inv = 1'b0;
                    state_reg <= md_start ? ST_MULDIV : ST_OUT;
                    unique case (op)
                        6'h00:
                        begin
                            if (fn == 6'h08)
                                npc = a_reg;
                            unique case (fn)
                                6'h00, 6'h02, 6'h03, 6'h08, 6'h0C, 6'h10, 6'h12,
                                6'h18, 6'h1A, 6'h20, 6'h21, 6'h22, 6'h24, 6'h25,
                                6'h26, 6'h27, 6'h2A: inv = 1'b0;
                                default: inv = 1'b1;
                            endcase
                        end
                        6'h02, 6'h03: npc = jtgt;
                        6'h04: if (a_reg == b_val) npc = btgt;
                        6'h05: if (a_reg != b_val) npc = btgt;
                        6'h06: if (a_reg == 32'd0 || a_reg[31]) npc = btgt;
                        6'h07: if (a_reg != 32'd0 && !a_reg[31]) npc = btgt;
                        default: npc = pc4;
                    endcase
                    pc_reg <= npc;
                    res_reg <= '{kind: (npc >= halt_reg) ? KIND_HALT : KIND_FETCH,
                                 mem_address: 32'd0, store_value: 32'd0,
                                 access_size: SIZE_BYTE, next_pc: npc,
                                 invalid_instr: inv};
                    unique case (op)
                        6'h20, 6'h24, 6'h21, 6'h25, 6'h23:
                        begin
                            ld_dest_reg <= rt;
                            ld_pend_reg <= 1'b1;
                            unique case (op)
                                6'h20:   ld_mode_reg <= LM_LB;
                                6'h24:   ld_mode_reg <= LM_LBU;
                                6'h21:   ld_mode_reg <= LM_LH;
                                6'h25:   ld_mode_reg <= LM_LHU;
                                default: ld_mode_reg <= LM_LW;
                            endcase
                            res_reg <= '{kind: KIND_LOAD, mem_address: addr,
                                         store_value: 32'd0,
                                         access_size: (op == 6'h23) ? SIZE_WORD :
                                             ((op == 6'h21 || op == 6'h25) ? SIZE_HALF
                                                                           : SIZE_BYTE),
                                         next_pc: npc, invalid_instr: 1'b0};
                        end
                        6'h28: res_reg <= '{kind: KIND_STORE, mem_address: addr,
                                            store_value: {24'd0, b_val[7:0]},
                                            access_size: SIZE_BYTE, next_pc: npc,
                                            invalid_instr: 1'b0};
                        6'h29: res_reg <= '{kind: KIND_STORE, mem_address: addr,
                                            store_value: {16'd0, b_val[15:0]},
                                            access_size: SIZE_HALF, next_pc: npc,
                                            invalid_instr: 1'b0};
                        6'h2B: res_reg <= '{kind: KIND_STORE, mem_address: addr,
                                            store_value: b_val,
                                            access_size: SIZE_WORD, next_pc: npc,
                                            invalid_instr: 1'b0};
                        default: ;
                    endcase
                end
                ST_MULDIV:
                begin
                    if (md_done)
                    begin
                        hi_reg    <= md_hi;
                        lo_reg    <= md_lo;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hold until the previous result has drained
                    if (!valid_reg || m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/riec_checker.sv -----
// Port-level checker for the integer execute core, bound to the top level.
// Depends on assert_macros.svh and riec_pkg.
`include "assert_macros.svh"
module riec_checker
    import riec_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         pready
);
    `CHK_IMPL(a_pready, clk, rst_n, 1'b1, pready)
    `CHK_NEXT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_IMPL(a_fetch_no_addr, clk, rst_n, m_tvalid && (m_tuser == KIND_FETCH || m_tuser == KIND_HALT), m_tdata[31:0] == 32'd0 && m_tdata[65:64] == SIZE_BYTE)
endmodule

bind risc_integer_execute_core riec_checker u_riec_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready)
);

// ----- verif/risc_integer_execute_core_tb.sv -----
// Self-checking testbench for risc_integer_execute_core: directed and random
// instruction streams, load replies and halt_address writes over APB.
// Depends on riec_pkg and the core RTL.
`timescale 1ns / 100ps

module risc_integer_execute_core_tb;
    import riec_pkg::*;

    // opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00, OP_J = 6'h02, OP_JAL = 6'h03;
    localparam logic [5:0] OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07;
    localparam logic [5:0] OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_SLTI = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B, OP_ANDI = 6'h0C, OP_ORI = 6'h0D;
    localparam logic [5:0] OP_XORI = 6'h0E, OP_LUI = 6'h0F;
    localparam logic [5:0] OP_LB = 6'h20, OP_LH = 6'h21, OP_LW = 6'h23;
    localparam logic [5:0] OP_LBU = 6'h24, OP_LHU = 6'h25;
    localparam logic [5:0] OP_SB = 6'h28, OP_SH = 6'h29, OP_SW = 6'h2B;
    localparam logic [5:0] OP_UNKNOWN = 6'h3F;
    // function codes
    localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_JR = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C, FN_MFHI = 6'h10, FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18, FN_DIV = 6'h1A, FN_ADD = 6'h20, FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB = 6'h22, FN_AND = 6'h24, FN_OR = 6'h25, FN_XOR = 6'h26;
    localparam logic [5:0] FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_UNKNOWN = 6'h01;

    localparam logic [1:0] REG_HALT_ADDR = 2'd0;
    localparam logic       REQ_INSTR = 1'b0, REQ_REPLY = 1'b1;
    localparam int         SETTLE_CYCLES = 60;

    localparam logic [5:0] RAND_OPS [26] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_SPECIAL,
        OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
        OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_SB, OP_SH, OP_SW};
    localparam logic [5:0] RAND_FNS [19] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_SYSCALL,
        FN_MFHI, FN_MFLO, FN_MULT, FN_DIV, FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR,
        FN_NOR, FN_SLT, FN_UNKNOWN, FN_UNKNOWN};

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // instr_word[31:0], load_value[63:32]
    logic         s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    // mem_address[31:0], store_value[63:32], access_size[65:64],
    // next_pc[97:66], invalid_instr[98], zero pad
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;   // result_kind
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor state
    logic [31:0] gpr [32];
    logic [31:0] hi_val, lo_val, pc_model, halt_addr;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_mode;
    logic        ld_pending;

    result_t     expected_results [$];
    int          errors = 0;
    int          n_requests = 0, n_results = 0, n_loads = 0, n_stores = 0, n_halted = 0;
    int          burst_left = 0;
    int          stall_cycle = 0;

    risc_integer_execute_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall pattern: always ready, random, then mostly stalled
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 300) % 3)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic void write_gpr(logic [4:0] r, logic [31:0] v);
        if (r != 5'd0)
            gpr[r] = v;
    endfunction

    // advance the core state by one request and return the expected result
    function automatic result_t execute_request(logic user, logic [31:0] w, logic [31:0] lv);
        result_t     r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [15:0] imm;
        logic [31:0] a, b, simm, addr, v, ma, mb, q, rem;
        logic [63:0] prod;
        r = '0;
        if (user == REQ_REPLY)
        begin
            if (ld_pending)
            begin
                case (ld_mode)
                    LM_LB:   v = {{24{lv[7]}}, lv[7:0]};
                    LM_LBU:  v = {24'd0, lv[7:0]};
                    LM_LH:   v = {{16{lv[15]}}, lv[15:0]};
                    LM_LHU:  v = {16'd0, lv[15:0]};
                    default: v = lv;
                endcase
                write_gpr(ld_dest, v);
                ld_pending = 1'b0;
            end
            r.kind = (pc_model >= halt_addr) ? KIND_HALT : KIND_FETCH;
            r.next_pc = pc_model;
            return r;
        end
        if (pc_model >= halt_addr || ld_pending)
        begin
            r.kind = (pc_model >= halt_addr) ? KIND_HALT : KIND_FETCH;
            r.next_pc = pc_model;
            return r;
        end
        op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
        fn = w[5:0]; imm = w[15:0];
        a = gpr[rs];
        b = gpr[rt];
        simm = {{16{imm[15]}}, imm};
        addr = a + simm;
        pc_model = pc_model + 32'd4;
        case (op)
            OP_SPECIAL:
                case (fn)
                    FN_SLL:     write_gpr(rd, b << sh);
                    FN_SRL:     write_gpr(rd, b >> sh);
                    FN_SRA:     write_gpr(rd, $unsigned($signed(b) >>> sh));
                    FN_JR:      pc_model = a;
                    FN_SYSCALL: ;
                    FN_MFHI:    write_gpr(rd, hi_val);
                    FN_MFLO:    write_gpr(rd, lo_val);
                    FN_MULT:
                    begin
                        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        hi_val = prod[63:32];
                        lo_val = prod[31:0];
                    end
                    FN_DIV:
                    begin
                        if (b == 32'd0)
                        begin
                            lo_val = 32'hFFFF_FFFF;
                            hi_val = a;
                        end
                        else if (a == SIGN_BIT && b == 32'hFFFF_FFFF)
                        begin
                            lo_val = SIGN_BIT;
                            hi_val = 32'd0;
                        end
                        else
                        begin
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            q = ma / mb;
                            rem = ma % mb;
                            lo_val = (a[31] ^ b[31]) ? -q : q;
                            hi_val = a[31] ? -rem : rem;
                        end
                    end
                    FN_ADD, FN_ADDU: write_gpr(rd, a + b);
                    FN_SUB:     write_gpr(rd, a - b);
                    FN_AND:     write_gpr(rd, a & b);
                    FN_OR:      write_gpr(rd, a | b);
                    FN_XOR:     write_gpr(rd, a ^ b);
                    FN_NOR:     write_gpr(rd, ~(a | b));
                    FN_SLT:     write_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                    default:    r.invalid_instr = 1'b1;
                endcase
            OP_JAL:
            begin
                write_gpr(5'd31, pc_model);
                pc_model = {pc_model[31:28], w[25:0], 2'b00};
            end
            OP_J:     pc_model = {pc_model[31:28], w[25:0], 2'b00};
            OP_BEQ:   if (a == b) pc_model = pc_model + (simm << 2);
            OP_BNE:   if (a != b) pc_model = pc_model + (simm << 2);
            OP_BLEZ:  if (a == 32'd0 || a[31]) pc_model = pc_model + (simm << 2);
            OP_BGTZ:  if (a != 32'd0 && !a[31]) pc_model = pc_model + (simm << 2);
            OP_ADDI, OP_ADDIU: write_gpr(rt, a + simm);
            OP_SLTI:  write_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
            OP_SLTIU: write_gpr(rt, {31'd0, a < simm});
            OP_ANDI:  write_gpr(rt, a & {16'd0, imm});
            OP_ORI:   write_gpr(rt, a | {16'd0, imm});
            OP_XORI:  write_gpr(rt, a ^ {16'd0, imm});
            OP_LUI:   write_gpr(rt, {imm, 16'd0});
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW:
            begin
                case (op)
                    OP_LB:
                    begin
                        ld_mode = LM_LB;
                        r.access_size = SIZE_BYTE;
                    end
                    OP_LBU:
                    begin
                        ld_mode = LM_LBU;
                        r.access_size = SIZE_BYTE;
                    end
                    OP_LH:
                    begin
                        ld_mode = LM_LH;
                        r.access_size = SIZE_HALF;
                    end
                    OP_LHU:
                    begin
                        ld_mode = LM_LHU;
                        r.access_size = SIZE_HALF;
                    end
                    default:
                    begin
                        ld_mode = LM_LW;
                        r.access_size = SIZE_WORD;
                    end
                endcase
                ld_dest = rt;
                ld_pending = 1'b1;
                r.kind = KIND_LOAD;
                r.mem_address = addr;
                r.next_pc = pc_model;
                return r;
            end
            OP_SB, OP_SH, OP_SW:
            begin
                r.kind = KIND_STORE;
                r.mem_address = addr;
                r.store_value = (op == OP_SB) ? {24'd0, b[7:0]} :
                                (op == OP_SH) ? {16'd0, b[15:0]} : b;
                r.access_size = (op == OP_SB) ? SIZE_BYTE :
                                (op == OP_SH) ? SIZE_HALF : SIZE_WORD;
                r.next_pc = pc_model;
                return r;
            end
            default: ;
        endcase
        r.kind = (pc_model >= halt_addr) ? KIND_HALT : KIND_FETCH;
        r.next_pc = pc_model;
        return r;
    endfunction

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // send one request; valid stays high on return so back-to-back requests need no gap
    task automatic send_request(logic user, logic [31:0] w, logic [31:0] lv);
        logic accepted;
        result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= {lv, w};
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        r = execute_request(user, w, lv);
        expected_results.push_back(r);
        n_requests++;
    endtask

    // hold off until every expected result has come and the core is idle
    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_halt_addr(logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_HALT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        halt_addr = value;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // sampled at the falling edge; the transfer completes at the next rising edge
    always @(negedge clk)
    begin
        result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("result_kind", 32'(e.kind), 32'(m_tuser));
                check_field("mem_address", e.mem_address, m_tdata[31:0]);
                check_field("store_value", e.store_value, m_tdata[63:32]);
                check_field("access_size", 32'(e.access_size), 32'(m_tdata[65:64]));
                check_field("next_pc", e.next_pc, m_tdata[97:66]);
                check_field("invalid_instr", 32'(e.invalid_instr), 32'(m_tdata[98]));
                n_results++;
                case (e.kind)
                    KIND_LOAD:  n_loads++;
                    KIND_STORE: n_stores++;
                    KIND_HALT:  n_halted++;
                    default: ;
                endcase
            end
        end
    end

    task automatic test_directed;
        send_request(REQ_INSTR, itype(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 32'd0);
        send_request(REQ_INSTR, itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 32'd0);
        send_request(REQ_INSTR, itype(OP_ADDI, 5'd0, 5'd2, 16'h8000), 32'd0);
        send_request(REQ_INSTR, itype(OP_LUI, 5'd0, 5'd3, 16'h7FFF), 32'd0);
        send_request(REQ_INSTR, itype(OP_ORI, 5'd3, 5'd3, 16'hFFFF), 32'd0);
        send_request(REQ_INSTR, rtype(FN_ADD, 5'd3, 5'd3, 5'd4, 5'd0), 32'd0);   // wraps
        send_request(REQ_INSTR, rtype(FN_SUB, 5'd2, 5'd3, 5'd5, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_SRA, 5'd0, 5'd1, 5'd6, 5'd31), 32'd0);
        send_request(REQ_INSTR, rtype(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0), 32'd0);
        // divide by zero
        send_request(REQ_INSTR, rtype(FN_DIV, 5'd3, 5'd0, 5'd0, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0), 32'd0);
        send_request(REQ_INSTR, itype(OP_LUI, 5'd0, 5'd9, 16'h8000), 32'd0);
        // overflow
        send_request(REQ_INSTR, rtype(FN_DIV, 5'd9, 5'd1, 5'd0, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_MFHI, 5'd0, 5'd0, 5'd10, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_MFLO, 5'd0, 5'd0, 5'd11, 5'd0), 32'd0);
        send_request(REQ_INSTR, rtype(FN_UNKNOWN, 5'd1, 5'd2, 5'd3, 5'd0), 32'd0);
        send_request(REQ_INSTR, itype(OP_UNKNOWN, 5'd1, 5'd2, 16'h1234), 32'd0);
        send_request(REQ_INSTR, rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0);
        // write to r0
        send_request(REQ_INSTR, itype(OP_ADDIU, 5'd1, 5'd0, 16'h0005), 32'd0);
        // nothing pending
        send_request(REQ_REPLY, 32'd0, 32'hDEAD_BEEF);
        send_request(REQ_INSTR, itype(OP_LB, 5'd2, 5'd12, 16'h7FFF), 32'd0);
        // ignored, load pending
        send_request(REQ_INSTR, itype(OP_SW, 5'd0, 5'd12, 16'h0000), 32'd0);
        send_request(REQ_REPLY, 32'd0, 32'hFFFF_FF80);
        send_request(REQ_INSTR, itype(OP_SH, 5'd12, 5'd1, 16'hFFFC), 32'd0);
        send_request(REQ_INSTR, itype(OP_BGTZ, 5'd3, 5'd0, 16'hFFFE), 32'd0);
        send_request(REQ_INSTR, {OP_JAL, 26'h3FF_FFFF}, 32'd0);
        send_request(REQ_INSTR, rtype(FN_JR, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0);
    endtask

    task automatic test_halt;
        write_halt_addr(pc_model + 32'd8);
        repeat (4) send_request(REQ_INSTR, 32'd0, 32'd0);
        send_request(REQ_REPLY, 32'd0, 32'h1234_5678);
        write_halt_addr(pc_model + 32'd4);
        // halts, still loads
        send_request(REQ_INSTR, itype(OP_LW, 5'd0, 5'd13, 16'h0100), 32'd0);
        send_request(REQ_INSTR, itype(OP_ADDI, 5'd0, 5'd14, 16'h0001), 32'd0);
        send_request(REQ_REPLY, 32'd0, 32'hCAFE_F00D);
        write_halt_addr(32'd0);
        send_request(REQ_INSTR, 32'd0, 32'd0);
        write_halt_addr(32'hFFFF_FFFF);
        send_request(REQ_INSTR, 32'd0, 32'd0);
    endtask

    task automatic send_random_instruction;
        logic [31:0] w;
        logic [5:0]  op;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            send_request(REQ_REPLY, 32'd0, $urandom);
            return;
        end
        w = $urandom;
        if (sel >= 12)
        begin
            op = RAND_OPS[$urandom_range(0, 25)];
            w[31:26] = op;
            if (op == OP_SPECIAL)
                w[5:0] = RAND_FNS[$urandom_range(0, 18)];
        end
        send_request(REQ_INSTR, w, 32'd0);
        if (ld_pending)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(REQ_INSTR, $urandom, 32'd0);
            send_request(REQ_REPLY, $urandom, $urandom);
        end
    endtask

    task automatic test_random(int count, logic [31:0] halt_value);
        write_halt_addr(halt_value);
        repeat (count) send_random_instruction();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        foreach (gpr[i])
            gpr[i] = 32'd0;
        hi_val = '0; lo_val = '0; pc_model = '0; halt_addr = HALT_RESET;
        ld_dest = '0; ld_mode = '0; ld_pending = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_halt();
        test_random(400, 32'hFFFF_FFFF);
        test_random(250, pc_model + 32'h0000_0400);
        test_random(400, 32'hFFFF_FFFF);
        test_random(150, HALT_RESET);
        drain();

        $display("Covered %0d requests: %0d results, %0d loads, %0d stores, %0d halted.",
                 n_requests, n_results, n_loads, n_stores, n_halted);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
